// ----- design/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed record ring stack package
// Transfer types and the record length rule shared by the design and checker.
// ----------------------------------------------------------------------------
package frs_pkg;

  // Longest record a frame may describe.
  localparam logic [6:0] MAX_RECORD = 7'd64;

  // Item kinds on the input channel.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // One input transfer.
  typedef struct packed {
    logic        kind;
    logic [6:0]  record_length;
    logic [15:0] word_value;
    logic        end_of_record;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [15:0] out_word;
    logic [6:0]  out_length;
    logic        last_of_run;
    logic        status;
    logic [11:0] free_words;
    logic        store_empty;
  } out_item_t;

  // A length word carries the count in its low seven bits, clamped to MAX_RECORD.
  function automatic logic [6:0] clamp_len(input logic [15:0] v);
    logic [6:0] n;
    n = v[6:0];
    return (n > MAX_RECORD) ? MAX_RECORD : n;
  endfunction

endpackage

// ----- design/frs_mem.sv -----
// ----------------------------------------------------------------------------
// Framed record ring stack word memory
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frs_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/frs_obuf.sv -----
// ----------------------------------------------------------------------------
// Framed record ring stack output register
// Holds one result transfer so the controller can move on while it waits.
// ----------------------------------------------------------------------------
module frs_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  frs_pkg::out_item_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output frs_pkg::out_item_t out_data
);

  logic               vld_r;
  logic               vld_nxt;
  frs_pkg::out_item_t data_r;

  // The register takes a new result when it is empty or being drained.
  assign push_ready = !vld_r || out_ready;
  assign vld_nxt    = push_valid || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- design/framed_record_ring_stack_top.sv -----
// ----------------------------------------------------------------------------
// Framed record ring stack
// Circular word store of length-framed records, pushed word by word, pulled
// newest record first.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds all records in one word RAM
// with a registered read, so its speed is set by the RAM port. A push word
// is written as its result is issued; the word that ends a record is written,
// then header and trailer are written, then the result is issued. The first
// word of a record first passes a fit check, and each oldest record it evicts
// adds a read of that record's header. A pull fetches the trailer, then
// delivers its words one per cycle while the output register takes them; a
// zero-length record or a pull on an empty store gives a single result. A
// finished result sits in an output register, so the next item is accepted
// while it waits. No clearing pass runs after reset.
module framed_record_ring_stack_top #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output frs_pkg::out_item_t out_data
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int AW1 = AW + 1;
  localparam int FW  = (AW > 12) ? AW : 12;
  localparam logic [AW:0] DEPTH_W = AW1'(STORE_DEPTH);

  // Controller states.
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EV_CHK    = 4'd1;
  localparam logic [3:0] ST_EV_RD     = 4'd2;
  localparam logic [3:0] ST_PUSH_WR   = 4'd3;
  localparam logic [3:0] ST_CMT_HDR   = 4'd4;
  localparam logic [3:0] ST_CMT_TRL   = 4'd5;
  localparam logic [3:0] ST_RESULT    = 4'd6;
  localparam logic [3:0] ST_PULL_LEN  = 4'd7;
  localparam logic [3:0] ST_PULL_WORD = 4'd8;

  // Modular address arithmetic; the second operand is always below the depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + DEPTH_W - {1'b0, b};
    end
    return s[AW-1:0];
  endfunction

  logic [3:0]        state_r,   state_nxt;
  logic [AW-1:0]     newest_r,  newest_nxt;
  logic [AW-1:0]     oldest_r,  oldest_nxt;
  logic [6:0]        pos_r,     pos_nxt;
  logic [6:0]        held_r,    held_nxt;
  logic [6:0]        cnt_r,     cnt_nxt;
  logic [6:0]        idx_r,     idx_nxt;
  logic [AW-1:0]     addr_r,    addr_nxt;
  logic [6:0]        res_len_r, res_len_nxt;
  logic              res_st_r,  res_st_nxt;
  frs_pkg::in_item_t item_r,    item_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [15:0]       mem_rdata;

  logic              res_valid;
  logic              res_ready;
  frs_pkg::out_item_t res_data;

  logic [AW-1:0]     free_w;
  logic [FW-1:0]     free_ext;
  logic [11:0]       free_sat;
  logic              empty_w;
  logic              accept;
  logic [6:0]        rd_len;
  logic [6:0]        pos_inc;
  logic [AW-1:0]     next_addr;

  // Occupancy: one slot always stays unused.
  assign empty_w  = (newest_r == oldest_r);
  assign free_w   = wrap_sub(wrap_sub(oldest_r, newest_r), AW'(1));
  assign free_ext = FW'(free_w);
  assign free_sat = (free_ext > FW'(4095)) ? 12'hFFF : free_ext[11:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign rd_len    = frs_pkg::clamp_len(mem_rdata);
  assign pos_inc   = pos_r + 7'd1;
  assign next_addr = wrap_add(addr_r, AW'(1));

  // Controller. The RAM is never read and written in the same cycle, and every
  // read is issued only after the write it depends on has been done.
  always_comb begin
    state_nxt   = state_r;
    newest_nxt  = newest_r;
    oldest_nxt  = oldest_r;
    pos_nxt     = pos_r;
    held_nxt    = held_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    addr_nxt    = addr_r;
    res_len_nxt = res_len_r;
    res_st_nxt  = res_st_r;
    item_nxt    = item_r;
    mem_we      = 1'b0;
    mem_waddr   = newest_r;
    mem_wdata   = 16'd0;
    mem_re      = 1'b0;
    mem_raddr   = newest_r;
    res_valid   = 1'b0;
    res_data    = '{out_word: 16'd0, out_length: res_len_r, last_of_run: 1'b1,
                    status: res_st_r, free_words: free_sat, store_empty: empty_w};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          if (in_data.kind == frs_pkg::KIND_PUSH) begin
            if (pos_r == 7'd0) begin
              held_nxt  = frs_pkg::clamp_len({9'd0, in_data.record_length});
              state_nxt = ST_EV_CHK;
            end else begin
              state_nxt = ST_PUSH_WR;
            end
          end else begin
            // A pull abandons any record in progress.
            pos_nxt = 7'd0;
            if (empty_w) begin
              res_len_nxt = 7'd0;
              res_st_nxt  = frs_pkg::STATUS_EMPTY;
              state_nxt   = ST_RESULT;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = wrap_sub(newest_r, AW'(1));
              state_nxt = ST_PULL_LEN;
            end
          end
        end
      end

      // Evict oldest records until the new record and its frame fit.
      ST_EV_CHK: begin
        if (({1'b0, free_w} >= (AW1'(held_r) + AW1'(2))) || empty_w) begin
          state_nxt = ST_PUSH_WR;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = oldest_r;
          state_nxt = ST_EV_RD;
        end
      end

      ST_EV_RD: begin
        oldest_nxt = wrap_add(oldest_r, AW'(rd_len) + AW'(2));
        state_nxt  = ST_EV_CHK;
      end

      // Store one record word behind the reserved header slot; a zero-length record stores none.
      ST_PUSH_WR: begin
        res_len_nxt = held_r;
        res_st_nxt  = frs_pkg::STATUS_OK;
        if (held_r == 7'd0) begin
          cnt_nxt   = 7'd0;
          state_nxt = ST_CMT_HDR;
        end else if (item_r.end_of_record || (pos_inc >= held_r)) begin
          mem_we    = 1'b1;
          mem_waddr = wrap_add(newest_r, AW'(pos_inc));
          mem_wdata = item_r.word_value;
          pos_nxt   = pos_inc;
          cnt_nxt   = pos_inc;
          state_nxt = ST_CMT_HDR;
        end else begin
          // Occupancy does not change, so the result goes out with the write.
          res_valid        = 1'b1;
          res_data.out_length = held_r;
          res_data.status  = frs_pkg::STATUS_OK;
          if (res_ready) begin
            mem_we    = 1'b1;
            mem_waddr = wrap_add(newest_r, AW'(pos_inc));
            mem_wdata = item_r.word_value;
            pos_nxt   = pos_inc;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_CMT_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = newest_r;
        mem_wdata = {9'd0, cnt_r};
        state_nxt = ST_CMT_TRL;
      end

      ST_CMT_TRL: begin
        mem_we     = 1'b1;
        mem_waddr  = wrap_add(newest_r, AW'(cnt_r) + AW'(1));
        mem_wdata  = {9'd0, cnt_r};
        newest_nxt = wrap_add(newest_r, AW'(cnt_r) + AW'(2));
        pos_nxt    = 7'd0;
        state_nxt  = ST_RESULT;
      end

      // Single result from registered length and status.
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      // Trailer arrived: pop the record and start reading its first word, or give the result if it is empty.
      ST_PULL_LEN: begin
        cnt_nxt    = rd_len;
        newest_nxt = wrap_sub(newest_r, AW'(rd_len) + AW'(2));
        if (rd_len == 7'd0) begin
          res_len_nxt = 7'd0;
          res_st_nxt  = frs_pkg::STATUS_OK;
          state_nxt   = ST_RESULT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wrap_sub(newest_r, AW'(rd_len) + AW'(1));
          addr_nxt  = mem_raddr;
          idx_nxt   = 7'd0;
          state_nxt = ST_PULL_WORD;
        end
      end

      // One word per transfer; the next read is issued as each word leaves.
      ST_PULL_WORD: begin
        res_valid            = 1'b1;
        res_data.out_word    = mem_rdata;
        res_data.out_length  = cnt_r;
        res_data.last_of_run = ((idx_r + 7'd1) == cnt_r);
        res_data.status      = frs_pkg::STATUS_OK;
        if (res_ready) begin
          if ((idx_r + 7'd1) == cnt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = next_addr;
            addr_nxt  = next_addr;
            idx_nxt   = idx_r + 7'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      newest_r <= '0;
      oldest_r <= '0;
      pos_r    <= 7'd0;
      held_r   <= 7'd0;
    end else begin
      state_r  <= state_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      pos_r    <= pos_nxt;
      held_r   <= held_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    addr_r    <= addr_nxt;
    res_len_r <= res_len_nxt;
    res_st_r  <= res_st_nxt;
    item_r    <= item_nxt;
  end

  frs_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frs_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res_data),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- design/frs_check.sv -----
// ----------------------------------------------------------------------------
// Framed record ring stack port checker
// Watches the top level's ports for rules of the result stream.
// ----------------------------------------------------------------------------
module frs_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input frs_pkg::out_item_t out_data
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An empty-store error is a lone, blank result.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == frs_pkg::STATUS_EMPTY) |->
      out_data.last_of_run && (out_data.out_word == 16'd0) &&
      (out_data.out_length == 7'd0) && out_data.store_empty)
    else $error("malformed empty-store error result");

  // Only pulled words of a nonempty record are followed by more results.
  a_run_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |->
      (out_data.status == frs_pkg::STATUS_OK) && (out_data.out_length != 7'd0))
    else $error("unexpected non-final result");

  // One item at a time: an accepted transfer closes the input in the cycle after it.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

endmodule

bind framed_record_ring_stack_top frs_check u_frs_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed record ring stack testbench
// Drives push and pull transfers into the ring stack, predicts every result
// from a private copy of the ring, and checks each result field by field.
// Covers empty pulls, zero-length and clamped records, early record ends,
// abandoned records, and a back-to-back fill followed by a full drain.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  frs_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  frs_pkg::out_item_t out_data;

  // Shared control between the test sequence and the receiver.
  bit no_idle       = 1'b0;
  int hold_requests = 0;
  int holds_taken   = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int items_sent    = 0;
  int stall_cycles  = 0;

  // Private copy of the ring: word store, both ends and the record in progress.
  logic [15:0] ring_mem [0:DEPTH-1];
  logic [11:0] newest_end = '0;
  logic [11:0] oldest_end = '0;
  int unsigned build_count = 0;
  int unsigned build_len   = 0;
  frs_pkg::out_item_t ring_results_due [$];

  framed_record_ring_stack_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Record length held in a length word: low seven bits, clamped.
  function automatic int unsigned frame_count(input logic [15:0] w);
    logic [6:0] n;
    n = w[6:0];
    return (n > frs_pkg::MAX_RECORD) ? frs_pkg::MAX_RECORD : n;
  endfunction

  // One slot always stays unused, so free space is one less than the gap.
  function automatic logic [11:0] ring_free();
    return oldest_end - newest_end - 12'd1;
  endfunction

  task automatic due_result(input logic [15:0] word, input int unsigned len,
                            input logic last, input logic status);
    frs_pkg::out_item_t r;
    r.out_word    = word;
    r.out_length  = 7'(len);
    r.last_of_run = last;
    r.status      = status;
    r.free_words  = ring_free();
    r.store_empty = (newest_end == oldest_end);
    ring_results_due.push_back(r);
  endtask

  // Write header and trailer, then move the newest end past the record.
  task automatic close_record(input int unsigned count);
    ring_mem[newest_end] = 16'(count);
    ring_mem[newest_end + 12'(count + 1)] = 16'(count);
    newest_end = newest_end + 12'(count + 2);
    build_count = 0;
  endtask

  task automatic predict_ring_results(input frs_pkg::in_item_t item);
    logic [11:0] trailer;
    logic [11:0] base;
    logic [15:0] pulled [0:63];
    int unsigned n;
    int unsigned guard;
    if (item.kind == frs_pkg::KIND_PUSH) begin
      if (build_count == 0) begin
        build_len = (item.record_length > frs_pkg::MAX_RECORD) ?
                    frs_pkg::MAX_RECORD : item.record_length;
        // Evict oldest records until the record and its two length words fit.
        guard = 0;
        while (!(ring_free() >= build_len + 2 || newest_end == oldest_end) &&
               guard < DEPTH) begin
          oldest_end = oldest_end + 12'(frame_count(ring_mem[oldest_end]) + 2);
          guard++;
        end
        if (build_len == 0) begin
          close_record(0);
          due_result('0, 0, 1'b1, frs_pkg::STATUS_OK);
          return;
        end
      end
      ring_mem[newest_end + 12'(build_count + 1)] = item.word_value;
      build_count++;
      if (item.end_of_record || build_count >= build_len)
        close_record(build_count);
      due_result('0, build_len, 1'b1, frs_pkg::STATUS_OK);
    end else begin
      // A pull drops any record in progress.
      build_count = 0;
      if (newest_end == oldest_end) begin
        due_result('0, 0, 1'b1, frs_pkg::STATUS_EMPTY);
        return;
      end
      trailer = newest_end - 12'd1;
      n = frame_count(ring_mem[trailer]);
      base = trailer - 12'(n);
      for (int unsigned x = 0; x < n; x++)
        pulled[x] = ring_mem[base + 12'(x)];
      newest_end = newest_end - 12'(n + 2);
      if (n == 0)
        due_result('0, 0, 1'b1, frs_pkg::STATUS_OK);
      else
        for (int unsigned x = 0; x < n; x++)
          due_result(pulled[x], n, (x + 1 == n), frs_pkg::STATUS_OK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_checker
    frs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (ring_results_due.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = ring_results_due.pop_front();
        check_field("out_word", out_data.out_word, want.out_word);
        check_field("out_length", out_data.out_length, want.out_length);
        check_field("last_of_run", out_data.last_of_run, want.last_of_run);
        check_field("status", out_data.status, want.status);
        check_field("free_words", out_data.free_words, want.free_words);
        check_field("store_empty", out_data.store_empty, want.store_empty);
      end
    end
  end

  // Stop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Receiver: random idling, long hold-offs on request.
  always @(negedge clk) begin : result_receiver
    if (hold_requests != holds_taken) begin
      holds_taken = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 9);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic frs_pkg::in_item_t make_item(input logic kind,
                                                  input logic [6:0] len,
                                                  input logic [15:0] word,
                                                  input logic eor);
    frs_pkg::in_item_t it;
    it.kind          = kind;
    it.record_length = len;
    it.word_value    = word;
    it.end_of_record = eor;
    return it;
  endfunction

  // Pull fields other than the kind carry random noise.
  function automatic frs_pkg::in_item_t make_pull();
    return make_item(frs_pkg::KIND_PULL, 7'($urandom_range(127)),
                     16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
  endfunction

  // Offer one item and wait for its transfer; predict at the accepting edge.
  task automatic send_item(input frs_pkg::in_item_t item);
    int unsigned gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_ring_results(item);
    items_sent++;
  endtask

  // Drop valid, then wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk);
  endtask

  // Push count items of one record; close sets end_of_record on the last one.
  task automatic push_record(input logic [6:0] len_field, input int unsigned count,
                             input logic close);
    logic [6:0] lf;
    for (int unsigned i = 0; i < count; i++) begin
      // Later items of a record ignore the length field, so vary it at times.
      lf = (i != 0 && $urandom_range(9) == 0) ? 7'($urandom_range(127)) : len_field;
      send_item(make_item(frs_pkg::KIND_PUSH, lf, 16'($urandom_range(16'hFFFF)),
                          (i + 1 == count) ? close : 1'b0));
    end
  endtask

  // Field extremes, empty pulls, zero-length, clamped and abandoned records.
  task automatic test_directed_cases();
    send_item(make_pull());
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd0, 16'hFFFF, 1'b0));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd3, 16'h0000, 1'b0));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd3, 16'hFFFF, 1'b0));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd3, 16'h1234, 1'b0));
    // Overlong length is clamped; the record then ends early.
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd127, 16'h8001, 1'b0));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd127, 16'h7FFE, 1'b1));
    send_item(make_pull());
    send_item(make_pull());
    send_item(make_pull());
    send_item(make_pull());
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd0, 16'h5A5A, 1'b1));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd1, 16'hFFFF, 1'b1));
    // A pull in the middle of a record abandons that record.
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd4, 16'hA5A5, 1'b0));
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd4, 16'h0001, 1'b0));
    send_item(make_pull());
    send_item(make_pull());
    send_item(make_pull());
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd64, 16'hFFFF, 1'b1));
    send_item(make_pull());
  endtask

  // Mixed records and pulls, with one long receiver hold-off and one drain pause.
  task automatic test_random_traffic();
    int          stop_at;
    logic [6:0]  len;
    int unsigned cl;
    int unsigned count;
    int unsigned pick;
    bit          held;
    bit          paused;
    stop_at = items_sent + 120;
    held = 1'b0;
    paused = 1'b0;
    while (items_sent < stop_at) begin
      if (!held && items_sent > stop_at - 90) begin
        hold_requests++;
        held = 1'b1;
      end
      if (!paused && items_sent > stop_at - 40) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 30) begin
        send_item(make_pull());
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = 7'($urandom_range(8));
        else if (pick < 90) len = 7'($urandom_range(64, 9));
        else                len = 7'($urandom_range(127, 65));
        cl = (len > frs_pkg::MAX_RECORD) ? frs_pkg::MAX_RECORD : len;
        pick = $urandom_range(99);
        if (cl == 0) begin
          push_record(len, 1, 1'($urandom_range(1)));
        end else if (pick < 15 && cl > 1) begin
          push_record(len, $urandom_range(cl - 1, 1), 1'b1);
        end else if (pick < 25 && cl > 1) begin
          count = $urandom_range(cl - 1, 1);
          push_record(len, count, 1'b0);
          send_item(make_pull());
        end else begin
          push_record(len, cl, 1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Push a run of records with no idling on either side, then pull them all back.
  task automatic test_fill_and_empty();
    logic [6:0] len;
    no_idle = 1'b1;
    repeat (3) begin
      len = 7'($urandom_range(10, 4));
      push_record(len, len, 1'($urandom_range(1)));
    end
    send_item(make_item(frs_pkg::KIND_PUSH, 7'd0, 16'h0000, 1'b1));
    no_idle = 1'b0;
    while (newest_end != oldest_end)
      send_item(make_pull());
    send_item(make_pull());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_fill_and_empty();
    wait_drained();
    repeat (20) @(posedge clk);
    if (ring_results_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                ring_results_due.size()));
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/frs_pkg.sv
design/frs_mem.sv
design/frs_obuf.sv
design/framed_record_ring_stack_top.sv
design/frs_check.sv
sim/testbench.sv
